### rtl/core/owbm_pkg.sv
`default_nettype none

package owbm_pkg;

  localparam int TIMER_BITS = 10;
  localparam int REG_BITS   = 10;
  localparam int PHASE_BITS = 4;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  // command codes
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // sequencer phases
  localparam logic [PHASE_BITS-1:0] PH_IDLE      = 4'd0;
  localparam logic [PHASE_BITS-1:0] PH_RST_LOW   = 4'd1;
  localparam logic [PHASE_BITS-1:0] PH_RST_WAIT  = 4'd2;
  localparam logic [PHASE_BITS-1:0] PH_RST_HIGH  = 4'd3;
  localparam logic [PHASE_BITS-1:0] PH_RST_REC   = 4'd4;
  localparam logic [PHASE_BITS-1:0] PH_WR_LOW    = 4'd5;
  localparam logic [PHASE_BITS-1:0] PH_WR_REST   = 4'd6;
  localparam logic [PHASE_BITS-1:0] PH_WR_REC    = 4'd7;
  localparam logic [PHASE_BITS-1:0] PH_RD_LOW    = 4'd8;
  localparam logic [PHASE_BITS-1:0] PH_RD_SAMPLE = 4'd9;
  localparam logic [PHASE_BITS-1:0] PH_RD_SLOT   = 4'd10;
  localparam logic [PHASE_BITS-1:0] PH_RD_REC    = 4'd11;

  // register indexes
  localparam logic [2:0] REG_RESET_LOW   = 3'd0;
  localparam logic [2:0] REG_RESET_HIGH  = 3'd1;
  localparam logic [2:0] REG_PRES_SAMPLE = 3'd2;
  localparam logic [2:0] REG_SLOT        = 3'd3;
  localparam logic [2:0] REG_WR_ONE_LOW  = 3'd4;
  localparam logic [2:0] REG_READ_LOW    = 3'd5;
  localparam logic [2:0] REG_RECOVERY    = 3'd6;

  localparam logic [REG_BITS-1:0] DEF_RESET_LOW   = 10'd480;
  localparam logic [REG_BITS-1:0] DEF_RESET_HIGH  = 10'd480;
  localparam logic [REG_BITS-1:0] DEF_PRES_SAMPLE = 10'd60;
  localparam logic [REG_BITS-1:0] DEF_SLOT        = 10'd90;
  localparam logic [REG_BITS-1:0] DEF_WR_ONE_LOW  = 10'd5;
  localparam logic [REG_BITS-1:0] DEF_READ_LOW    = 10'd2;
  localparam logic [REG_BITS-1:0] DEF_RECOVERY    = 10'd2;

  typedef logic [TIMER_BITS-1:0] timer_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] tx_byte;
    logic       crc_clear;
    logic       line_in;
    logic       us_tick;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_byte;
    logic [7:0] crc_value;
  } res_t;

  typedef struct packed {
    logic [REG_BITS-1:0] reset_low_us;
    logic [REG_BITS-1:0] reset_high_us;
    logic [REG_BITS-1:0] presence_sample_us;
    logic [REG_BITS-1:0] slot_us;
    logic [REG_BITS-1:0] write_one_low_us;
    logic [REG_BITS-1:0] read_low_us;
    logic [REG_BITS-1:0] recovery_us;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    timer_t                time_left;
    logic [2:0]            bit_count;
    logic [7:0]            shift_data;
    logic                  presence_seen;
    logic [7:0]            crc_reg;
    logic [7:0]            read_result;
  } state_t;

  // register value to timer width (zero extend or truncate)
  function automatic timer_t to_timer(input logic [REG_BITS-1:0] v);
    logic [TIMER_BITS+REG_BITS-1:0] w;
    w = {{TIMER_BITS{1'b0}}, v};
    return w[TIMER_BITS-1:0];
  endfunction

  function automatic logic [REG_BITS-1:0] sat_sub(input logic [REG_BITS-1:0] a,
                                                  input logic [REG_BITS-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // reflected CRC-8, LSB first
  function automatic logic [7:0] crc_fold(input logic [7:0] crc_in,
                                          input logic [7:0] data);
    logic [7:0] c;
    logic       mix;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      mix = c[0] ^ data[k];
      c   = {1'b0, c[7:1]};
      if (mix) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/one_wire_bus_master.sv
// 1-wire bus master, one beat per clock of the bus timing domain. Each input beat carries
// a microsecond strobe, an optional command (bus reset, write byte, read byte; taken only
// when idle), a CRC clear and the sampled line level; each beat yields exactly one result
// beat with the line drive, busy, done pulse, presence, last read byte and running CRC-8.
// An accepted item passes the input register, then the result register, with the sequencer
// state updated in between; a new beat is accepted every cycle as long as results are
// taken. Timings come from the seven 10-bit registers on the config port, which is always
// ready and must be written only while no command is in progress.
`default_nettype none

module one_wire_bus_master (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 item_valid,
  output logic                item_ready,
  input  owbm_pkg::item_t     item,
  output logic                res_valid,
  input  wire                 res_ready,
  output owbm_pkg::res_t      res,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [2:0]           cfg_index,
  input  wire [9:0]           cfg_data
);
  import owbm_pkg::*;

  item_t  s_item;
  logic   s_valid;
  logic   adv;
  cfg_t   cfg;
  state_t state;
  state_t state_next;
  res_t   res_next;

  assign adv        = s_valid && (!res_valid || res_ready);
  assign item_ready = !s_valid || adv;
  assign cfg_ready  = 1'b1;

  owbm_step u_step (
    .item (s_item),
    .cfg  (cfg),
    .cur  (state),
    .nxt  (state_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s_item <= item;
    end
    if (adv) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      res_valid <= 1'b0;
      state     <= '{phase: PH_IDLE, default: '0};
    end else begin
      if (item_ready) begin
        s_valid <= item_valid;
      end
      if (adv) begin
        state     <= state_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_us       <= DEF_RESET_LOW;
      cfg.reset_high_us      <= DEF_RESET_HIGH;
      cfg.presence_sample_us <= DEF_PRES_SAMPLE;
      cfg.slot_us            <= DEF_SLOT;
      cfg.write_one_low_us   <= DEF_WR_ONE_LOW;
      cfg.read_low_us        <= DEF_READ_LOW;
      cfg.recovery_us        <= DEF_RECOVERY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RESET_LOW:   cfg.reset_low_us       <= cfg_data;
        REG_RESET_HIGH:  cfg.reset_high_us      <= cfg_data;
        REG_PRES_SAMPLE: cfg.presence_sample_us <= cfg_data;
        REG_SLOT:        cfg.slot_us            <= cfg_data;
        REG_WR_ONE_LOW:  cfg.write_one_low_us   <= cfg_data;
        REG_READ_LOW:    cfg.read_low_us        <= cfg_data;
        REG_RECOVERY:    cfg.recovery_us        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/owbm_step.sv
`default_nettype none

module owbm_step (
  input  owbm_pkg::item_t  item,
  input  owbm_pkg::cfg_t   cfg,
  input  owbm_pkg::state_t cur,
  output owbm_pkg::state_t nxt,
  output owbm_pkg::res_t   res
);
  import owbm_pkg::*;

  timer_t tl;
  logic   done;

  always_comb begin
    nxt  = cur;
    done = 1'b0;
    tl   = cur.time_left;

    if (item.crc_clear) begin
      nxt.crc_reg = '0;
    end

    if (cur.phase == PH_IDLE) begin
      nxt.bit_count = '0;
      case (item.op)
        OP_RESET: begin
          nxt.phase     = PH_RST_LOW;
          nxt.time_left = to_timer(cfg.reset_low_us);
        end
        OP_WRITE: begin
          nxt.shift_data = item.tx_byte;
          nxt.phase      = PH_WR_LOW;
          nxt.time_left  = item.tx_byte[0] ? to_timer(cfg.write_one_low_us)
                                           : to_timer(cfg.slot_us);
        end
        OP_READ: begin
          nxt.shift_data = '0;
          nxt.phase      = PH_RD_LOW;
          nxt.time_left  = to_timer(cfg.read_low_us);
        end
        default: begin
        end
      endcase
    end else begin
      if (tl != '0 && item.us_tick) begin
        tl = tl - 1'b1;
      end
      nxt.time_left = tl;
      // phase runs out in the same beat the count reaches zero
      if (tl == '0) begin
        case (cur.phase)
          PH_RST_LOW: begin
            nxt.phase     = PH_RST_WAIT;
            nxt.time_left = to_timer(cfg.presence_sample_us);
          end
          PH_RST_WAIT: begin
            nxt.presence_seen = ~item.line_in;
            nxt.phase         = PH_RST_HIGH;
            nxt.time_left     = to_timer(sat_sub(cfg.reset_high_us,
                                                 cfg.presence_sample_us));
          end
          PH_RST_HIGH: begin
            nxt.phase     = PH_RST_REC;
            nxt.time_left = to_timer(cfg.recovery_us);
          end
          PH_WR_LOW: begin
            nxt.phase     = PH_WR_REST;
            nxt.time_left = cur.shift_data[0]
                          ? to_timer(sat_sub(cfg.slot_us, cfg.write_one_low_us))
                          : '0;
          end
          PH_WR_REST: begin
            nxt.phase     = PH_WR_REC;
            nxt.time_left = to_timer(cfg.recovery_us);
          end
          PH_WR_REC: begin
            nxt.shift_data = {1'b0, cur.shift_data[7:1]};
            if (cur.bit_count == 3'd7) begin
              nxt.bit_count = '0;
              nxt.phase     = PH_IDLE;
              nxt.time_left = '0;
              done          = 1'b1;
            end else begin
              nxt.bit_count = cur.bit_count + 3'd1;
              nxt.phase     = PH_WR_LOW;
              nxt.time_left = cur.shift_data[1] ? to_timer(cfg.write_one_low_us)
                                                : to_timer(cfg.slot_us);
            end
          end
          PH_RD_LOW: begin
            nxt.phase     = PH_RD_SAMPLE;
            nxt.time_left = '0;
          end
          PH_RD_SAMPLE: begin
            nxt.shift_data = {item.line_in, cur.shift_data[7:1]};
            nxt.phase      = PH_RD_SLOT;
            nxt.time_left  = to_timer(cfg.slot_us);
          end
          PH_RD_SLOT: begin
            nxt.phase     = PH_RD_REC;
            nxt.time_left = to_timer(cfg.recovery_us);
          end
          PH_RD_REC: begin
            if (cur.bit_count == 3'd7) begin
              nxt.bit_count   = '0;
              nxt.read_result = cur.shift_data;
              // clear, when present, applies before the fold
              nxt.crc_reg     = crc_fold(item.crc_clear ? 8'h00 : cur.crc_reg,
                                         cur.shift_data);
              nxt.phase       = PH_IDLE;
              nxt.time_left   = '0;
              done            = 1'b1;
            end else begin
              nxt.bit_count = cur.bit_count + 3'd1;
              nxt.phase     = PH_RD_LOW;
              nxt.time_left = to_timer(cfg.read_low_us);
            end
          end
          default: begin
            // reset recovery and unused codes
            nxt.phase     = PH_IDLE;
            nxt.time_left = '0;
            done          = 1'b1;
          end
        endcase
      end
    end

    res.drive_low = (nxt.phase == PH_RST_LOW) || (nxt.phase == PH_WR_LOW)
                 || (nxt.phase == PH_RD_LOW);
    res.busy_res  = (nxt.phase != PH_IDLE);
    res.done_res  = done;
    res.presence  = nxt.presence_seen;
    res.rx_byte   = nxt.read_result;
    res.crc_value = nxt.crc_reg;
  end

endmodule

`default_nettype wire

### rtl/core/owbm_checker.sv
`default_nettype none

module owbm_checker (
  input wire            clk,
  input wire            rst,
  input wire            res_valid,
  input wire            res_ready,
  input owbm_pkg::res_t res
);
  import owbm_pkg::*;

  // a stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.done_res |-> !res.busy_res)
    else $error("done with busy still set");

  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.drive_low |-> res.busy_res)
    else $error("bus driven low while idle");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

`default_nettype wire
